// ===== hw/rtl/owus_pkg.sv =====
// ----------------------------------------------------------------------------
// owus_pkg
// Shared types, codes and CRC functions for the 1-Wire over UART slot engine.
// ----------------------------------------------------------------------------
package owus_pkg;

  // Request codes carried on the input tuser.
  localparam logic [2:0] MODE_RESET = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_READ  = 3'd2;
  localparam logic [2:0] MODE_RX    = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  // Presence status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_NODEV   = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic [7:0] SLOT_RESET = 8'hF0;
  localparam logic [7:0] ECHO_PRES  = 8'hE0;
  localparam logic [7:0] SLOT_ONE   = 8'hFF;
  localparam logic [7:0] SLOT_ZERO  = 8'h00;
  localparam logic [7:0] CRC8_POLY  = 8'h8C;
  localparam logic [15:0] CRC16_POLY = 16'hC001;
  localparam logic [7:0] DISCARD_SAT = 8'd247;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_W       = 48;

  // One queued job for the back end. A write job expands into eight slots,
  // and then tx_byte holds the byte being written.
  typedef struct packed {
    logic        multi;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        baud;
    logic [7:0]  read_value;
    logic        byte_valid;
    logic [1:0]  status;
    logic [7:0]  crc8;
    logic [15:0] crc16;
  } entry_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] v;
    logic       mix;
    c = crc;
    v = b;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ v[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CRC8_POLY;
      end
      v = v >> 1;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] cd;
    logic [15:0] c;
    cd = {8'h00, b ^ crc[7:0]};
    c  = crc >> 8;
    if (^cd[7:0]) begin
      c = c ^ CRC16_POLY;
    end
    c = c ^ (cd << 6);
    c = c ^ (cd << 7);
    return c;
  endfunction

endpackage

// ===== hw/rtl/owus_front.sv =====
// ----------------------------------------------------------------------------
// owus_front
// Accepts requests and echoes, keeps the bus state and CRCs, queues jobs.
// ----------------------------------------------------------------------------
module owus_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [2:0]          mode,
  input  logic [7:0]          data_byte,
  output logic                push,
  output owus_pkg::entry_t    push_entry
);
  import owus_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_PRESENCE, PH_READING} phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  slot_index, slot_index_next;
  logic [7:0]  assembled_byte, assembled_byte_next;
  logic [7:0]  echoes, echoes_next;
  logic        speed_mode, speed_mode_next;
  logic [7:0]  crc8_reg, crc8_next_v;
  logic [15:0] crc16_reg, crc16_next_v;
  logic        emit;
  entry_t      e;
  logic [7:0]  merged;

  always_comb begin
    phase_next          = phase;
    slot_index_next     = slot_index;
    assembled_byte_next = assembled_byte;
    echoes_next         = echoes;
    speed_mode_next     = speed_mode;
    crc8_next_v         = crc8_reg;
    crc16_next_v        = crc16_reg;
    emit                = 1'b0;
    e                   = '0;
    merged              = assembled_byte;
    merged[slot_index]  = (data_byte == SLOT_ONE);
    unique case (mode)
      MODE_RESET: begin
        speed_mode_next = 1'b1;
        phase_next      = PH_PRESENCE;
        slot_index_next = '0;
        emit            = 1'b1;
        e.tx_byte       = SLOT_RESET;
        e.tx_valid      = 1'b1;
      end
      MODE_WRITE: begin
        speed_mode_next = 1'b0;
        phase_next      = PH_IDLE;
        slot_index_next = '0;
        crc8_next_v     = crc8_next(crc8_reg, data_byte);
        crc16_next_v    = crc16_next(crc16_reg, data_byte);
        echoes_next     = (echoes > DISCARD_SAT) ? 8'hFF : echoes + 8'd8;
        emit            = 1'b1;
        e.multi         = 1'b1;
        e.tx_byte       = data_byte;
        e.tx_valid      = 1'b1;
      end
      MODE_READ: begin
        speed_mode_next     = 1'b0;
        phase_next          = PH_READING;
        slot_index_next     = '0;
        assembled_byte_next = '0;
        emit                = 1'b1;
        e.tx_byte           = SLOT_ONE;
        e.tx_valid          = 1'b1;
      end
      MODE_RX: begin
        if (echoes != 8'd0) begin
          echoes_next = echoes - 8'd1;
        end else if (phase == PH_PRESENCE) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          e.status   = (data_byte == ECHO_PRES)  ? ST_PRESENT :
                       (data_byte == SLOT_RESET) ? ST_NODEV : ST_BAD;
        end else if (phase == PH_READING) begin
          assembled_byte_next = merged;
          emit                = 1'b1;
          if (slot_index == 3'd7) begin
            crc8_next_v     = crc8_next(crc8_reg, merged);
            crc16_next_v    = crc16_next(crc16_reg, merged);
            phase_next      = PH_IDLE;
            slot_index_next = '0;
            e.read_value    = merged;
            e.byte_valid    = 1'b1;
          end else begin
            slot_index_next = slot_index + 3'd1;
            e.tx_byte       = SLOT_ONE;
            e.tx_valid      = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        crc8_next_v  = '0;
        crc16_next_v = '0;
        emit         = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    e.baud  = speed_mode_next;
    e.crc8  = crc8_next_v;
    e.crc16 = crc16_next_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      slot_index     <= '0;
      assembled_byte <= '0;
      echoes         <= '0;
      speed_mode     <= 1'b1;
      crc8_reg       <= '0;
      crc16_reg      <= '0;
      push           <= 1'b0;
    end else begin
      push <= accept && emit;
      if (accept) begin
        phase          <= phase_next;
        slot_index     <= slot_index_next;
        assembled_byte <= assembled_byte_next;
        echoes         <= echoes_next;
        speed_mode     <= speed_mode_next;
        crc8_reg       <= crc8_next_v;
        crc16_reg      <= crc16_next_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    push_entry <= e;
  end

  // The discard count only moves down by one echo at a time.
  a_discard_step: assert property (@(posedge clk) disable iff (rst)
    (echoes < $past(echoes)) |-> (echoes == $past(echoes) - 8'd1))
    else $error("discard count dropped by more than one");

endmodule

// ===== hw/rtl/owus_queue.sv =====
// ----------------------------------------------------------------------------
// owus_queue
// Small register queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module owus_queue #(
  parameter int DEPTH = owus_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  owus_pkg::entry_t push_entry,
  input  logic             pop,
  output owus_pkg::entry_t head,
  output logic             head_valid,
  output logic             full,
  output logic             afull
);
  import owus_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] AFULL_C  = CW'(DEPTH - 1);

  entry_t        store [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head       = store[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == DEPTH_C);
  assign afull      = (count >= AFULL_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job queue underflow");

endmodule

// ===== hw/rtl/owus_back.sv =====
// ----------------------------------------------------------------------------
// owus_back
// Expands queued jobs into result items and holds them in the output register.
// ----------------------------------------------------------------------------
module owus_back (
  input  logic                          clk,
  input  logic                          rst,
  input  owus_pkg::entry_t              head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [owus_pkg::OUT_W-1:0]    m_tdata,
  output logic                          m_tlast
);
  import owus_pkg::*;

  entry_t     cur;
  logic       busy;
  logic [2:0] slot;
  logic       load_out;

  function automatic logic [OUT_W-1:0] pack(input entry_t en, input logic [2:0] s);
    logic [7:0] tx;
    tx = en.multi ? (en.tx_byte[s] ? SLOT_ONE : SLOT_ZERO) : en.tx_byte;
    return {3'b000, en.crc16, en.crc8, en.status, en.byte_valid, en.read_value,
            en.baud, en.tx_valid, tx};
  endfunction

  assign load_out = !m_tvalid || m_tready;
  assign pop      = load_out && !busy && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      busy     <= 1'b0;
      slot     <= '0;
    end else if (load_out) begin
      if (busy) begin
        m_tvalid <= 1'b1;
        m_tdata  <= pack(cur, slot);
        m_tlast  <= (slot == 3'd7);
        busy     <= (slot != 3'd7);
        slot     <= slot + 3'd1;
      end else if (head_valid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= pack(head, 3'd0);
        m_tlast  <= !head.multi;
        busy     <= head.multi;
        cur      <= head;
        slot     <= 3'd1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_busy_slot: assert property (@(posedge clk) disable iff (rst)
    busy |-> (slot != 3'd0))
    else $error("slot counter zero while expanding a write");

  // A result that is not the last of its run can only come from a write in progress.
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> busy)
    else $error("unterminated run without a write in progress");

endmodule

// ===== hw/rtl/onewire_uart_slot_engine.sv =====
// A result passes the front's registered push, the job queue and the back
// end's output register. Throughput: one request per cycle while s_tready is
// high; a write request holds the output side for eight results, one per
// slot, while the front keeps queuing up to the job queue depth. Synchronous
// reset returns reset speed, idle bus state, zero CRCs and an empty job queue.
// ----------------------------------------------------------------------------
// onewire_uart_slot_engine
// 1-Wire master slot engine over a half-duplex UART, front/back decoupled.
// ----------------------------------------------------------------------------
module onewire_uart_slot_engine #(
  parameter int QUEUE_DEPTH = owus_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // data_byte[7:0]
  input  logic [2:0]                 s_tuser,   // mode[2:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // tx_byte[7:0], tx_valid[8], baud_select[9], read_value[17:10],
  // byte_valid[18], status[20:19], crc8_value[28:21], crc16_value[44:29]
  output logic [owus_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import owus_pkg::*;

  logic   push, pop, head_valid, full, afull, accept;
  entry_t push_entry, head;

  // One slack slot keeps the registered push from landing in a full queue.
  logic near_full;
  assign near_full = full || (push && !pop && afull);

  assign s_tready = !near_full;
  assign accept   = s_tvalid && s_tready;

  owus_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (s_tuser),
    .data_byte  (s_tdata),
    .push       (push),
    .push_entry (push_entry)
  );

  owus_queue #(.DEPTH(QUEUE_DEPTH + 1)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full),
    .afull      (afull)
  );

  owus_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== tb/owus_slot_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// owus_slot_checker
// Watches both stream ports of the slot engine, predicts the slot results of
// every accepted request and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module owus_slot_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // data_byte[7:0]
  input  logic [2:0]                 s_tuser,   // mode[2:0]
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  // tx_byte[7:0], tx_valid[8], baud_select[9], read_value[17:10],
  // byte_valid[18], status[20:19], crc8_value[28:21], crc16_value[44:29]
  input  logic [owus_pkg::OUT_W-1:0] m_tdata,
  input  logic                       m_tlast,
  output int                         outstanding,
  output int                         fail_count,
  output int                         requests_seen,
  output int                         results_seen
);
  import owus_pkg::*;

  typedef enum logic [1:0] {
    BUS_IDLE,
    AWAIT_PRESENCE,
    BUS_READING
  } bus_phase_t;

  typedef struct packed {
    logic [7:0]  tx;
    logic        tx_v;
    logic        baud;
    logic [7:0]  rd;
    logic        rd_v;
    logic [1:0]  st;
    logic [7:0]  c8;
    logic [15:0] c16;
    logic        lst;
  } slot_result_t;

  bus_phase_t   bus_phase;
  logic [2:0]   bit_pos;
  logic [7:0]   rx_byte;
  logic [7:0]   discard_left;
  logic         reset_speed;
  logic [7:0]   crc8_acc;
  logic [15:0]  crc16_acc;
  slot_result_t slot_results_q[$];
  int           mismatches;

  // Plain bitwise forms of the reflected CRCs (0x8C for CRC-8, 0xA001 for CRC-16).
  function automatic logic [7:0] dow_crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] dow_crc16(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    crc8_acc  = dow_crc8(crc8_acc, b);
    crc16_acc = dow_crc16(crc16_acc, b);
  endtask

  task automatic push_result(input logic [7:0] tx, input logic tx_v, input logic [7:0] rd,
                             input logic rd_v, input logic [1:0] st, input logic lst);
    slot_result_t r;
    r.tx   = tx;
    r.tx_v = tx_v;
    r.baud = reset_speed;
    r.rd   = rd;
    r.rd_v = rd_v;
    r.st   = st;
    r.c8   = crc8_acc;
    r.c16  = crc16_acc;
    r.lst  = lst;
    slot_results_q.push_back(r);
  endtask

  task automatic predict_request(input logic [2:0] mode, input logic [7:0] d);
    logic [1:0] st;
    case (mode)
      MODE_RESET: begin
        reset_speed = 1'b1;
        bus_phase   = AWAIT_PRESENCE;
        bit_pos     = 3'd0;
        push_result(SLOT_RESET, 1'b1, 8'h00, 1'b0, ST_NONE, 1'b1);
      end
      MODE_WRITE: begin
        reset_speed = 1'b0;
        bus_phase   = BUS_IDLE;
        bit_pos     = 3'd0;
        take_byte(d);
        discard_left = (discard_left > DISCARD_SAT) ? 8'hFF : discard_left + 8'd8;
        for (int i = 0; i < 8; i++) begin
          push_result(d[i] ? SLOT_ONE : SLOT_ZERO, 1'b1, 8'h00, 1'b0, ST_NONE, i == 7);
        end
      end
      MODE_READ: begin
        reset_speed = 1'b0;
        bus_phase   = BUS_READING;
        bit_pos     = 3'd0;
        rx_byte     = 8'h00;
        push_result(SLOT_ONE, 1'b1, 8'h00, 1'b0, ST_NONE, 1'b1);
      end
      MODE_RX: begin
        // Echoes of written slots are swallowed before anything else sees them.
        if (discard_left != 8'd0) begin
          discard_left = discard_left - 8'd1;
        end else if (bus_phase == AWAIT_PRESENCE) begin
          st = (d == ECHO_PRES) ? ST_PRESENT : (d == SLOT_RESET) ? ST_NODEV : ST_BAD;
          bus_phase = BUS_IDLE;
          push_result(8'h00, 1'b0, 8'h00, 1'b0, st, 1'b1);
        end else if (bus_phase == BUS_READING) begin
          rx_byte[bit_pos] = (d == SLOT_ONE);
          if (bit_pos == 3'd7) begin
            take_byte(rx_byte);
            bus_phase = BUS_IDLE;
            bit_pos   = 3'd0;
            push_result(8'h00, 1'b0, rx_byte, 1'b1, ST_NONE, 1'b1);
          end else begin
            bit_pos = bit_pos + 3'd1;
            push_result(SLOT_ONE, 1'b1, 8'h00, 1'b0, ST_NONE, 1'b1);
          end
        end
      end
      MODE_CLEAR: begin
        crc8_acc  = 8'h00;
        crc16_acc = 16'h0000;
        push_result(8'h00, 1'b0, 8'h00, 1'b0, ST_NONE, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    slot_result_t want;
    slot_result_t got;
    string        bad;
    if (rst) begin
      bus_phase    = BUS_IDLE;
      bit_pos      = 3'd0;
      rx_byte      = 8'h00;
      discard_left = 8'h00;
      reset_speed  = 1'b1;
      crc8_acc     = 8'h00;
      crc16_acc    = 16'h0000;
      slot_results_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_request(s_tuser, s_tdata);
        requests_seen <= requests_seen + 1;
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got.tx   = m_tdata[7:0];
        got.tx_v = m_tdata[8];
        got.baud = m_tdata[9];
        got.rd   = m_tdata[17:10];
        got.rd_v = m_tdata[18];
        got.st   = m_tdata[20:19];
        got.c8   = m_tdata[28:21];
        got.c16  = m_tdata[44:29];
        got.lst  = m_tlast;
        if (slot_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result, nothing pending: tdata=%012h last=%b",
                     $time, m_tdata, m_tlast);
          end
        end else begin
          want = slot_results_q.pop_front();
          bad  = "";
          if (got.tx != want.tx) bad = {bad, " tx_byte"};
          if (got.tx_v != want.tx_v) bad = {bad, " tx_valid"};
          if (got.baud != want.baud) bad = {bad, " baud_select"};
          if (got.rd != want.rd) bad = {bad, " read_value"};
          if (got.rd_v != want.rd_v) bad = {bad, " byte_valid"};
          if (got.st != want.st) bad = {bad, " status"};
          if (got.c8 != want.c8) bad = {bad, " crc8"};
          if (got.c16 != want.c16) bad = {bad, " crc16"};
          if (got.lst != want.lst) bad = {bad, " last"};
          if (m_tdata[47:45] != 3'b000) bad = {bad, " padding"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch in%s", $time, bad);
              $display({"  expected tx=%02h/%b baud=%b rd=%02h/%b st=%0d",
                        " crc8=%02h crc16=%04h last=%b"},
                       want.tx, want.tx_v, want.baud, want.rd, want.rd_v, want.st,
                       want.c8, want.c16, want.lst);
              $display({"  actual   tx=%02h/%b baud=%b rd=%02h/%b st=%0d",
                        " crc8=%02h crc16=%04h last=%b"},
                       got.tx, got.tx_v, got.baud, got.rd, got.rd_v, got.st,
                       got.c8, got.c16, got.lst);
            end
          end
        end
      end
    end
    outstanding <= slot_results_q.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives reset, presence, write, read and clear requests into the slot engine
// under several handshake mixes and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import owus_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 42;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [7:0]          s_tdata  = 8'h00;
  logic [2:0]          s_tuser  = MODE_CLEAR;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tlast;

  int   outstanding;
  int   fail_count;
  int   requests_seen;
  int   results_seen;
  int   idle_pct;
  int   stall_pct;
  int   items_sent;
  int   hold_left;
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;

  int idle_mix[4]  = '{0, 47, 0, 38};
  int stall_mix[4] = '{0, 0, 47, 38};

  always #4 clk = ~clk;

  onewire_uart_slot_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  owus_slot_checker slot_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .outstanding   (outstanding),
    .fail_count    (fail_count),
    .requests_seen (requests_seen),
    .results_seen  (results_seen)
  );

  // Receiver side. A toggle of hold_flip starts one long hold-off.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_req(input logic [2:0] mode, input logic [7:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] echo_byte();
    case ($urandom_range(3))
      0: return SLOT_ONE;
      1: return SLOT_ZERO;
      2: return 8'($urandom_range(255));
      default: return SLOT_ONE;
    endcase
  endfunction

  // Mostly complete bus transactions with random content; some are cut short
  // so that the next request abandons them, and a few are plain noise.
  task automatic random_sequence();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 18) begin
      send_req(MODE_RESET, 8'($urandom_range(255)));
      case ($urandom_range(3))
        0: b = ECHO_PRES;
        1: b = SLOT_RESET;
        default: b = 8'($urandom_range(255));
      endcase
      send_req(MODE_RX, b);
    end else if (pick < 42) begin
      b = 8'($urandom_range(255));
      send_req(MODE_WRITE, b);
      for (int i = 0; i < 8; i++) begin
        send_req(MODE_RX, b[i] ? SLOT_ONE : echo_byte());
      end
    end else if (pick < 72) begin
      send_req(MODE_READ, 8'($urandom_range(255)));
      repeat (8) send_req(MODE_RX, echo_byte());
    end else if (pick < 80) begin
      send_req(MODE_CLEAR, 8'($urandom_range(255)));
    end else if (pick < 90) begin
      case ($urandom_range(2))
        0: send_req(MODE_RESET, 8'($urandom_range(255)));
        1: send_req(MODE_WRITE, 8'($urandom_range(255)));
        default: send_req(MODE_READ, 8'($urandom_range(255)));
      endcase
      n = $urandom_range(1, 7);
      repeat (n) send_req(MODE_RX, echo_byte());
    end else begin
      send_req(3'($urandom_range(7)), 8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int          target;
    logic [7:0]  read_echoes[8];
    idle_pct   = 0;
    items_sent = 0;
    read_echoes = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFE, 8'h7F, 8'hFF, 8'h00};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: ignored items, every presence outcome, extreme bytes,
    // a read with mixed echoes and an abandoned read.
    send_req(MODE_CLEAR, 8'h00);
    send_req(MODE_RX, 8'h55);
    for (int m = MODE_CLEAR + 1; m < 8; m++) begin
      send_req(3'(m), 8'hFF);
    end
    send_req(MODE_RESET, 8'h00);
    send_req(MODE_RX, ECHO_PRES);
    send_req(MODE_RESET, 8'hFF);
    send_req(MODE_RX, SLOT_RESET);
    send_req(MODE_RESET, 8'h00);
    send_req(MODE_RX, 8'h00);
    send_req(MODE_WRITE, 8'h00);
    send_req(MODE_WRITE, 8'hFF);
    repeat (16) send_req(MODE_RX, echo_byte());
    send_req(MODE_READ, 8'h00);
    for (int i = 0; i < 8; i++) begin
      send_req(MODE_RX, read_echoes[i]);
    end
    send_req(MODE_READ, 8'hFF);
    repeat (8) send_req(MODE_RX, SLOT_ONE);
    send_req(MODE_READ, 8'h00);
    repeat (3) send_req(MODE_RX, SLOT_ONE);
    send_req(MODE_RESET, 8'h00);
    send_req(MODE_RX, ECHO_PRES);
    send_req(MODE_CLEAR, 8'hFF);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct <= stall_mix[p];
      target    = items_sent + PHASE_ITEMS;
      if (p == 2) begin
        // Long output hold-off while requests keep coming back to back.
        hold_flip <= ~hold_flip;
      end
      while (items_sent < target) random_sequence();
      drain_results();
    end

    // Push the echo-discard count into saturation. Every echo that follows
    // must still be swallowed, which a count that wrapped past zero would not do.
    repeat (32) send_req(MODE_WRITE, 8'($urandom_range(255)));
    send_req(MODE_RESET, 8'h00);
    send_req(MODE_RX, ECHO_PRES);
    send_req(MODE_RX, ECHO_PRES);
    send_req(MODE_READ, 8'h00);
    repeat (8) send_req(MODE_RX, SLOT_ONE);
    drain_results();

    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("Run covered %0d requests and %0d checked results over four handshake mixes,",
             requests_seen, results_seen);
    $display("with a long output hold-off and a saturated echo-discard count.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
